[rtl/core/sma_pkg.sv]
`timescale 1ns / 1ps

package sma_pkg;

  // Fixed field widths
  localparam int unsigned WL_W      = 7;
  localparam int unsigned MEAN_W    = 24;
  localparam int unsigned FILLED_W  = 7;
  localparam int unsigned FRAC_BITS = 8;

  localparam logic [WL_W-1:0] WL_RESET = 7'd3;

  // Parameter defaults
  localparam int unsigned MAX_WINDOW_DEF  = 64;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Depth of the queue between front and divider
  localparam int unsigned QUEUE_DEPTH = 2;

endpackage

[rtl/core/sma_fifo.sv]
`timescale 1ns / 1ps

module sma_fifo import sma_pkg::*; #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/core/sma_front.sv]
`timescale 1ns / 1ps

module sma_front import sma_pkg::*; #(
  parameter int unsigned MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned SUM_W       = SAMPLE_BITS + $clog2(MAX_WINDOW),
  parameter int unsigned LEN_W       = $clog2(MAX_WINDOW + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [WL_W-1:0]               cfg_wdata_i,
  input  logic                          push_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          busy_o,
  output logic                          q_push_o,
  output logic [SUM_W+LEN_W-1:0]        q_wdata_o,
  input  logic                          q_full_i
);

  localparam int unsigned PTR_W = $clog2(MAX_WINDOW);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_RD   = 3'b010,
    F_PUSH = 3'b100
  } front_state_e;

  front_state_e state_q, state_d;

  logic [WL_W-1:0]               wl_q;
  logic [PTR_W-1:0]              ptr_q, ptr_d;
  logic [PTR_W-1:0]              slot_q, slot;
  logic [LEN_W-1:0]              fill_q, fill_d;
  logic signed [SUM_W-1:0]       sum_q, sum_d;
  logic signed [SAMPLE_BITS-1:0] smp_q;
  logic signed [SAMPLE_BITS-1:0] hist_q [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] old_q;
  logic [LEN_W-1:0]              len;
  logic [LEN_W:0]                slot_inc;
  logic                          accept;

  // Effective window length: zero acts as one, oversize clamps
  always_comb begin
    if (wl_q == '0) begin
      len = LEN_W'(1);
    end else if (32'(wl_q) > MAX_WINDOW) begin
      len = LEN_W'(MAX_WINDOW);
    end else begin
      len = LEN_W'(wl_q);
    end
  end

  assign accept = push_i && (state_q == F_IDLE);
  assign busy_o = (state_q != F_IDLE);
  assign slot   = ((LEN_W + 1)'(ptr_q) >= (LEN_W + 1)'(len)) ? '0 : ptr_q;

  assign slot_inc = (LEN_W + 1)'(slot_q) + 1'b1;

  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    fill_d  = fill_q;
    sum_d   = sum_q;
    case (state_q)
      F_IDLE: begin
        if (push_i) begin
          state_d = F_RD;
        end
      end
      F_RD: begin
        if (fill_q < len) begin
          fill_d = fill_q + 1'b1;
          sum_d  = sum_q + SUM_W'(smp_q);
        end else begin
          sum_d = sum_q - SUM_W'(old_q) + SUM_W'(smp_q);
        end
        ptr_d   = (slot_inc >= (LEN_W + 1)'(len)) ? '0 : PTR_W'(slot_inc);
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign q_push_o  = (state_q == F_PUSH) && !q_full_i;
  assign q_wdata_o = {sum_q, fill_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      wl_q    <= WL_RESET;
      ptr_q   <= '0;
      fill_q  <= '0;
      sum_q   <= '0;
    end else if (cfg_we_i) begin
      wl_q   <= cfg_wdata_i;
      ptr_q  <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      fill_q  <= fill_d;
      sum_q   <= sum_d;
    end
  end

  // Sample ring: registered read at accept, write-back in the F_RD state
  always_ff @(posedge clk_i) begin
    old_q <= hist_q[slot];
    if (accept) begin
      smp_q  <= sample_i;
      slot_q <= slot;
    end
    if (state_q == F_RD) begin
      hist_q[slot_q] <= smp_q;
    end
  end

endmodule

[rtl/core/sma_div.sv]
`timescale 1ns / 1ps

module sma_div import sma_pkg::*; #(
  parameter int unsigned SUM_W = 22,
  parameter int unsigned LEN_W = 7,
  parameter int unsigned N_W   = SUM_W + FRAC_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [SUM_W-1:0] sum_i,
  input  logic [LEN_W-1:0]        cnt_i,
  output logic                    ready_o,
  output logic                    done_o,
  input  logic                    take_i,
  output logic signed [N_W:0]     res_o,
  output logic [LEN_W-1:0]        cnt_o
);

  localparam int unsigned IT_W = $clog2(N_W + 1);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_RUN  = 3'b010,
    D_DONE = 3'b100
  } div_state_e;

  div_state_e       state_q, state_d;
  logic [N_W-1:0]   quo_q, quo_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic [LEN_W-1:0] den_q;
  logic [IT_W-1:0]  it_q, it_d;
  logic             neg_q;
  logic [N_W-1:0]   num;
  logic [N_W-1:0]   mag;
  logic [LEN_W:0]   rem_sh;
  logic [LEN_W:0]   rem_sub;
  logic             fits;
  logic [N_W:0]     qx;

  // Numerator is sum scaled by 2^FRAC_BITS; divide the magnitude
  assign num = {sum_i, FRAC_BITS'(0)};
  assign mag = sum_i[SUM_W-1] ? (~num + 1'b1) : num;

  assign rem_sh  = {rem_q, quo_q[N_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign fits    = (rem_sh >= {1'b0, den_q});

  assign ready_o = (state_q == D_IDLE);
  assign done_o  = (state_q == D_DONE);
  assign qx      = {1'b0, quo_q};
  assign res_o   = $signed(neg_q ? (~qx + 1'b1) : qx);
  assign cnt_o   = den_q;

  always_comb begin
    state_d = state_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    it_d    = it_q;
    case (state_q)
      D_IDLE: begin
        if (start_i) begin
          quo_d   = mag;
          rem_d   = '0;
          it_d    = IT_W'(N_W);
          state_d = D_RUN;
        end
      end
      D_RUN: begin
        quo_d = {quo_q[N_W-2:0], fits};
        rem_d = fits ? LEN_W'(rem_sub) : LEN_W'(rem_sh);
        it_d  = it_q - 1'b1;
        if (it_q == IT_W'(1)) begin
          state_d = D_DONE;
        end
      end
      D_DONE: begin
        if (take_i) begin
          state_d = D_IDLE;
        end
      end
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      it_q    <= '0;
    end else begin
      state_q <= state_d;
      it_q    <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i && ready_o) begin
      neg_q <= sum_i[SUM_W-1];
      den_q <= cnt_i;
    end
  end

endmodule

[rtl/core/simple_moving_average.sv]
`timescale 1ns / 1ps

// Simple moving average over the last window_length signed samples. Every
// accepted sample yields one result: the window mean as signed fixed point
// with 8 fraction bits (truncated toward zero) and the number of samples now
// held. During warm-up the mean is over the samples seen so far. Writing
// window_length (0 acts as 1, values above MAX_WINDOW clamp) empties the
// window; write it only while no transaction is in flight. The front end
// takes a sample, reads the oldest entry from the sample ring (registered
// read), updates the running sum and queues sum and count; it takes no new
// sample until the sum is queued. The back end is a radix-2 restoring
// divider that takes SAMPLE_BITS + log2(MAX_WINDOW) + 8 iterations and
// accepts no new sum until its result is taken; it sets the sustained rate.
// A two-entry queue sits between front and divider and an output register
// holds the finished result, so the input side keeps moving while a result
// waits to be popped. No clearing pass is needed after reset.
module simple_moving_average import sma_pkg::*; #(
  parameter int unsigned MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config
  input  logic                          cfg_we_i,
  input  logic [WL_W-1:0]               cfg_wdata_i,
  // sample queue side
  input  logic                          push,
  output logic                          full,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  // result queue side
  output logic                          empty,
  input  logic                          pop,
  output logic signed [MEAN_W-1:0]      mean_o,
  output logic [FILLED_W-1:0]           filled_o
);

  localparam int unsigned SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int unsigned LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned N_W   = SUM_W + FRAC_BITS;
  localparam int unsigned QD_W  = SUM_W + LEN_W;

  logic                    q_push, q_full, q_empty, q_pop;
  logic [QD_W-1:0]         q_wdata, q_rdata;
  logic                    div_ready, div_done, div_take, div_start;
  logic signed [N_W:0]     div_res;
  logic [LEN_W-1:0]        div_cnt;
  logic                    out_valid_q;
  logic signed [MEAN_W-1:0] mean_q;
  logic [FILLED_W-1:0]     filled_q;

  sma_front #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS),
    .SUM_W      (SUM_W),
    .LEN_W      (LEN_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push_i     (push),
    .sample_i   (sample_i),
    .busy_o     (full),
    .q_push_o   (q_push),
    .q_wdata_o  (q_wdata),
    .q_full_i   (q_full)
  );

  sma_fifo #(
    .WIDTH(QD_W)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i(q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .rdata_o(q_rdata),
    .empty_o(q_empty)
  );

  // Divider pulls a queued sum as soon as it is free
  assign div_start = !q_empty && div_ready;
  assign q_pop     = div_start;

  sma_div #(
    .SUM_W(SUM_W),
    .LEN_W(LEN_W),
    .N_W  (N_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .sum_i  ($signed(q_rdata[QD_W-1:LEN_W])),
    .cnt_i  (q_rdata[LEN_W-1:0]),
    .ready_o(div_ready),
    .done_o (div_done),
    .take_i (div_take),
    .res_o  (div_res),
    .cnt_o  (div_cnt)
  );

  // Output register: reloads on the same edge the held result is popped
  assign div_take = div_done && (!out_valid_q || pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (div_take) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_take) begin
      mean_q   <= MEAN_W'(div_res);
      filled_q <= FILLED_W'(div_cnt);
    end
  end

  assign empty    = !out_valid_q;
  assign mean_o   = mean_q;
  assign filled_o = filled_q;

  // A held result always counts at least one sample
  assert property (@(posedge clk_i) disable iff (!rst_ni) !empty |-> filled_o != '0)
    else $error("result with zero fill count");

  // Front never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("queue overflow");

  // Divider result is never dropped: a finished result stays until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done && !div_take |=> div_done)
    else $error("divider result lost");

  // The output register is only reloaded when it is free or being popped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_take |-> (empty || pop))
    else $error("output register overwritten");

endmodule
